// File: rtl/csm_pkg.sv
// Shared types and codes for the communication mode supervisor.
`default_nettype none
package csm_pkg;

  // Item kinds.
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_BASE   = 3'd1;
  localparam logic [2:0] KIND_SUB    = 3'd2;
  localparam logic [2:0] KIND_SYNC   = 3'd3;
  localparam logic [2:0] KIND_HEALTH = 3'd4;

  // Base mode codes.
  localparam logic [2:0] MODE_BOOT      = 3'd0;
  localparam logic [2:0] MODE_CALIBRATE = 3'd1;
  localparam logic [2:0] MODE_READY     = 3'd2;
  localparam logic [2:0] MODE_EMERGENCY = 3'd3;
  localparam logic [2:0] MODE_LOW_BATT  = 3'd4;
  localparam logic [2:0] MODE_ERROR     = 3'd5;

  localparam logic [1:0] SUB_IDLE = 2'd0;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY     = 1'd1;

  localparam logic [15:0] SYNC_TIMEOUT_RESET = 16'd500;
  localparam logic [7:0]  RECOVERY_RESET     = 8'd5;

  localparam logic [31:0] AGE_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] target_mode;
    logic [1:0] target_sub;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  base_mode;
    logic [2:0]  prior_mode;
    logic [1:0]  sub_mode;
    logic [1:0]  prior_sub;
    logic [31:0] time_in_mode;
    logic        comm_active;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  prior_mode;
    logic [1:0]  sub;
    logic [1:0]  prior_sub;
    logic [31:0] mode_age;
    logic [31:0] sync_age;
    logic [7:0]  sync_tally;
  } sup_state_t;

  typedef struct packed {
    logic [15:0] sync_timeout;
    logic [7:0]  recovery;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/comm_supervisor_mode_fsm.sv
// Top level of the communication mode supervisor.
// The result of an accepted beat is registered in the output register.
// Throughput: one item per cycle while out_ready holds; the state update is a single pass through csm_next.
// The input is ready whenever the output register is empty or is being drained.
// Reset (synchronous, active high) returns to BOOT, clears all counters and
// loads the timeout and recovery registers with 500 and 5.
`default_nettype none
module comm_supervisor_mode_fsm
  import csm_pkg::*;
#(
  parameter int unsigned SUB_MODES = 4
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  sup_state_t state;
  sup_state_t state_next;
  out_item_t  result;
  logic       in_beat;

  csm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csm_next #(
    .SUB_MODES (SUB_MODES)
  ) u_next (
    .item   (in_data),
    .cur    (state),
    .cfg    (cfg),
    .nxt    (state_next),
    .result (result)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  // Supervisor state, updated on each input beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode       <= MODE_BOOT;
      state.prior_mode <= MODE_BOOT;
      state.sub        <= SUB_IDLE;
      state.prior_sub  <= SUB_IDLE;
      state.mode_age   <= 32'd0;
      state.sync_age   <= 32'd0;
      state.sync_tally <= 8'd0;
    end else if (in_beat) begin
      state <= state_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_data <= result;
    end
  end

  // A reported base mode is always a defined code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.base_mode <= MODE_ERROR)
    else $error("base mode out of range");

  // A nonidle sub-mode only exists in READY.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.sub_mode != SUB_IDLE) |-> out_data.base_mode == MODE_READY)
    else $error("sub-mode set outside READY");

  // Right after a sync beat, communication is active unless the timeout is zero.
  assert property (@(posedge clk) disable iff (rst)
    (in_beat && in_data.kind == KIND_SYNC && !cfg_we) |=>
      (out_data.comm_active == (cfg.sync_timeout != 16'd0)))
    else $error("sync beat did not restore comm_active");

  // A rejected health check never shows a mode change made by the same beat.
  assert property (@(posedge clk) disable iff (rst)
    (in_beat && in_data.kind == KIND_HEALTH && !result.accepted) |=>
      (out_data.base_mode == $past(state.mode)))
    else $error("health check changed mode without acceptance");

endmodule
`default_nettype wire

// File: rtl/csm_cfg.sv
// Configuration registers of the mode supervisor.
`default_nettype none
module csm_cfg
  import csm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  // Register file, written one register per write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_timeout <= SYNC_TIMEOUT_RESET;
      cfg.recovery     <= RECOVERY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_TIMEOUT: cfg.sync_timeout <= cfg_data[15:0];
        CFG_RECOVERY:     cfg.recovery     <= cfg_data[7:0];
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/csm_next.sv
// Next-state and result logic of the mode supervisor for one beat.
`default_nettype none
module csm_next
  import csm_pkg::*;
#(
  parameter int unsigned SUB_MODES = 4
)
(
  input  wire in_item_t   item,
  input  wire sup_state_t cur,
  input  wire cfg_t       cfg,
  output sup_state_t      nxt,
  output out_item_t       result
);

  logic        ok;
  logic        timed_out;
  logic        in_sync;
  logic        sub_valid;
  logic [31:0] timeout_ext;

  assign timeout_ext = {16'd0, cfg.sync_timeout};
  assign timed_out   = cur.sync_age > timeout_ext;
  assign in_sync     = cur.sync_age < timeout_ext;
  assign sub_valid   = 32'(item.target_sub) < 32'(SUB_MODES);

  // Apply the item to the current state.
  always_comb begin
    nxt = cur;
    ok  = 1'b0;
    unique case (item.kind)
      KIND_TICK: begin
        if (cur.mode_age != AGE_MAX) nxt.mode_age = cur.mode_age + 32'd1;
        if (cur.sync_age != AGE_MAX) nxt.sync_age = cur.sync_age + 32'd1;
        ok = 1'b1;
      end
      KIND_BASE: begin
        if (item.target_mode <= MODE_ERROR) begin
          ok = 1'b1;
          if (item.target_mode != cur.mode) begin
            nxt.prior_mode = cur.mode;
            nxt.mode       = item.target_mode;
            nxt.mode_age   = 32'd0;
            if (item.target_mode != MODE_READY) nxt.sub = SUB_IDLE;
          end
        end
      end
      KIND_SUB: begin
        if (cur.mode == MODE_READY && sub_valid) begin
          nxt.prior_sub = cur.sub;
          nxt.sub       = item.target_sub;
          ok            = 1'b1;
        end
      end
      KIND_SYNC: begin
        nxt.sync_age = 32'd0;
        if (cur.sync_tally < cfg.recovery) nxt.sync_tally = cur.sync_tally + 8'd1;
        ok = 1'b1;
      end
      KIND_HEALTH: begin
        // Outside ERROR and BOOT a sync timeout forces ERROR.
        if (cur.mode != MODE_ERROR && cur.mode != MODE_BOOT) begin
          if (timed_out) begin
            nxt.sync_tally = 8'd0;
            nxt.prior_mode = cur.mode;
            nxt.mode       = MODE_ERROR;
            nxt.mode_age   = 32'd0;
            nxt.sub        = SUB_IDLE;
            ok             = 1'b1;
          end
        end else if (cur.mode == MODE_ERROR) begin
          // Recovery once communication is stable again.
          if (in_sync && cur.sync_tally >= cfg.recovery) begin
            nxt.prior_mode = cur.mode;
            nxt.mode       = MODE_CALIBRATE;
            nxt.mode_age   = 32'd0;
            nxt.sub        = SUB_IDLE;
            ok             = 1'b1;
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Result seen after this beat.
  always_comb begin
    result.accepted     = ok;
    result.base_mode    = nxt.mode;
    result.prior_mode   = nxt.prior_mode;
    result.sub_mode     = nxt.sub;
    result.prior_sub    = nxt.prior_sub;
    result.time_in_mode = nxt.mode_age;
    result.comm_active  = nxt.sync_age < timeout_ext;
  end

endmodule
`default_nettype wire
